/* hw/rtl/sha_pkg.sv */
// SHA-256 package: round constants, initial hash values, sequencer state type.
// No dependencies.
`default_nettype none
package sha_pkg;
    localparam int BlockBytes = 64;
    localparam int Rounds     = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } core_ctl_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] i);
        logic [31:0] h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

/* hw/rtl/sha_round.sv */
// SHA-256 compression unit: one round per cycle, rolling 16-word schedule.
// Depends on sha_pkg. Block words are loaded in parallel on start.
`default_nettype none
module sha_round (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sha_pkg::core_ctl_t ctl_in,
    input  wire logic [511:0]      block_in,
    input  wire logic [255:0]      hash_in,
    output logic [255:0]           hash_out,
    output logic                   done
);
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [5:0]  r_reg;
    logic        run_reg, done_reg;
    logic [31:0] w, w15, w2, s0, s1, t1, t2, e, a;

    always_comb begin
        w15 = w_reg[1];
        w2  = w_reg[14];
        s0  = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
        s1  = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
        w   = w_reg[0];
        e   = v_reg[4];
        a   = v_reg[0];
        t1  = v_reg[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
            + ((e & v_reg[5]) ^ (~e & v_reg[6])) + sha_pkg::round_k(r_reg) + w;
        t2  = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
            + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            r_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl_in.start) begin
                run_reg <= 1'b1;
                r_reg   <= '0;
            end else if (run_reg) begin
                r_reg <= r_reg + 6'd1;
                if (r_reg == 6'(sha_pkg::Rounds - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.start) begin
            for (int j = 0; j < 16; j++) w_reg[j] <= block_in[511 - 32*j -: 32];
            for (int j = 0; j < 8; j++) v_reg[j] <= hash_in[255 - 32*j -: 32];
        end else if (run_reg) begin
            for (int j = 0; j < 15; j++) w_reg[j] <= w_reg[j+1];
            w_reg[15] <= w_reg[0] + s0 + w_reg[9] + s1;
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_comb begin
        for (int j = 0; j < 8; j++) hash_out[255 - 32*j -: 32] = v_reg[j];
    end
    assign done = done_reg;

    a_done_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !run_reg) else $error("done while running");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg && r_reg != 6'd63 |=> run_reg) else $error("round run cut short");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_in.start |-> !run_reg) else $error("start while busy");
endmodule
`default_nettype wire

/* hw/rtl/sha256_stream_hasher.sv */
// Streaming SHA-256 hasher: at most one byte per input beat, digest out as 8 words.
// Depends on sha_pkg and sha_round.
//
// Input beat: s_data_byte/s_has_byte/s_last. A beat that does not fill the block
// and is not the last leaves s_ready high. A beat that fills the 64-byte block
// holds s_ready low through the load, the compression rounds and the hash add.
// A last beat pads the message (one pad byte per cycle up to byte 64, one or two
// blocks), compresses, then sends 8 m_ beats, word 0 first, m_last_word on word 7;
// s_ready stays low until word 7 is taken. A stalled m_ready holds the word.
// Reset (synchronous aresetn low): hash words to initial values, count and
// length to zero, no output pending.
`default_nettype none
module sha256_stream_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_has_byte,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_digest_word,
    output logic [2:0]       m_word_index,
    output logic             m_last_word
);
    sha_pkg::state_t state_reg, state_next;
    logic [511:0] buf_reg;
    logic [5:0]   fill_reg;
    logic [63:0]  bits_reg, len_reg;
    logic [255:0] hash_reg;
    logic [2:0]   idx_reg;
    logic         fin_reg;
    logic [255:0] core_hash;
    logic [511:0] block_flat;
    logic         core_done;
    sha_pkg::core_ctl_t ctl;
    logic         acc, wr_en, fill_full;
    logic [7:0]   wr_byte;
    logic [255:0] hash_sum;
    logic [7:0]   pad_byte;
    logic         pad_done_reg, pad80_reg, wrap_reg;

    always_comb begin
        block_flat = buf_reg;
        for (int j = 0; j < 8; j++)
            hash_sum[255 - 32*j -: 32] = hash_reg[255 - 32*j -: 32] + core_hash[255 - 32*j -: 32];
    end

    assign acc = s_valid && s_ready;
    assign fill_full = (fill_reg == 6'd63);

    always_comb begin
        state_next = state_reg;
        s_ready = 1'b0;
        wr_en = 1'b0;
        wr_byte = s_data_byte;
        ctl = '0;
        case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (acc) begin
                    wr_en = s_has_byte;
                    if (s_has_byte && fill_full) state_next = sha_pkg::ST_LOAD;
                    else if (s_last) state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD: begin
                wr_en = 1'b1;
                if (fill_full) state_next = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_LOAD: begin
                ctl.start = 1'b1;
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND: begin
                if (core_done) state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD: begin
                if (fin_reg && pad_done_reg) state_next = sha_pkg::ST_OUT;
                else if (fin_reg) state_next = sha_pkg::ST_PAD;
                else state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_OUT: begin
                if (m_ready && idx_reg == 3'd7) state_next = sha_pkg::ST_IDLE;
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // length field in the last 8 bytes, but not in a block whose 0x80 sits at byte 56 or later
    always_comb begin
        if (!pad80_reg) pad_byte = 8'h80;
        else if (fill_reg >= 6'd56 && !wrap_reg)
            pad_byte = len_reg[8*(6'd63 - fill_reg) +: 8];
        else pad_byte = 8'h00;
    end

    always_ff @(posedge aclk) begin
        if (wr_en)
            buf_reg <= {buf_reg[503:0], (state_reg == sha_pkg::ST_PAD) ? pad_byte : wr_byte};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sha_pkg::ST_IDLE;
            fill_reg <= '0;
            bits_reg <= '0;
            len_reg <= '0;
            fin_reg <= 1'b0;
            pad80_reg <= 1'b0;
            pad_done_reg <= 1'b0;
            wrap_reg <= 1'b0;
            idx_reg <= '0;
            for (int j = 0; j < 8; j++) hash_reg[255 - 32*j -: 32] <= sha_pkg::init_h(3'(j));
        end else begin
            state_reg <= state_next;
            if (state_reg == sha_pkg::ST_IDLE && acc) begin
                if (s_has_byte) begin
                    fill_reg <= fill_reg + 6'd1;
                    bits_reg <= bits_reg + 64'd8;
                end
                if (s_last) begin
                    fin_reg <= 1'b1;
                    pad80_reg <= 1'b0;
                    pad_done_reg <= 1'b0;
                    wrap_reg <= 1'b0;
                    len_reg <= s_has_byte ? bits_reg + 64'd8 : bits_reg;
                end
            end
            if (state_reg == sha_pkg::ST_PAD) begin
                fill_reg <= fill_reg + 6'd1;
                pad80_reg <= 1'b1;
                if (!pad80_reg && fill_reg >= 6'd56) wrap_reg <= 1'b1;
                if (fill_full && pad80_reg && !wrap_reg) pad_done_reg <= 1'b1;
            end
            if (state_reg == sha_pkg::ST_ADD) begin
                hash_reg <= hash_sum;
                wrap_reg <= 1'b0;
            end
            if (state_reg == sha_pkg::ST_OUT && m_ready) begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7) begin
                    fin_reg <= 1'b0;
                    bits_reg <= '0;
                    fill_reg <= '0;
                    for (int j = 0; j < 8; j++)
                        hash_reg[255 - 32*j -: 32] <= sha_pkg::init_h(3'(j));
                end
            end
        end
    end

    sha_round u_round (
        .aclk(aclk), .aresetn(aresetn), .ctl_in(ctl), .block_in(block_flat),
        .hash_in(hash_reg), .hash_out(core_hash), .done(core_done)
    );

    assign m_valid = (state_reg == sha_pkg::ST_OUT);
    assign m_digest_word = hash_reg[255 - 32*idx_reg -: 32];
    assign m_word_index = idx_reg;
    assign m_last_word = (idx_reg == 3'd7);

    a_out_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> fin_reg) else $error("digest without end mark");
    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid) else $error("input taken during output");
    a_idx_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> idx_reg == 3'd0) else $error("digest starts mid word");
endmodule
`default_nettype wire
